// File: hw/rtl/hds_pkg.sv
package hds_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 4;
    localparam int K_W         = 16;
    localparam int SIZE_CFG_W  = 11;

    // k is Q2.14 and the neighbour sum is divided by 8
    localparam int K_FRAC_SHIFT = 17;

    localparam logic [K_W-1:0]        K_RESET    = 16'd16384;
    localparam logic [SIZE_CFG_W-1:0] SIZE_RESET = 11'd3;
    localparam int                    SIZE_MIN   = 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_LVL_W = 3;

    typedef enum logic [1:0] {
        REG_CONDUCT_K = 2'd0,
        REG_GRID_COLS = 2'd1,
        REG_GRID_ROWS = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [K_W-1:0]        conduct_k;
        logic [SIZE_CFG_W-1:0] grid_cols;
        logic [SIZE_CFG_W-1:0] grid_rows;
    } t_cfg;

    typedef struct packed {
        logic grid_end;
        logic row_end;
    } t_flags;

endpackage

// File: hw/rtl/heat_diffusion_stencil_3x3.sv
// channel      | direction | beat contents
// s_axis       | in        | tdata: old_temp
// m_axis       | out       | tdata: new_temp, tuser: row_end, tlast: grid_end
// apb          | in/out    | conduct_k at 0x0, grid_cols at 0x4, grid_rows at 0x8
//
// one grid cell per cycle sustained while m_axis_tready holds; a result reaches the
// output register through the s1 register, queue write, neighbour sum,
// multiply by k, then halve with floor and saturate
// synchronous reset clears counters, window and queue; line stores are not cleared
// output stalls fill a four-entry queue, then s_axis_tready drops
module heat_diffusion_stencil_3x3 #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int TEMP_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((TEMP_WIDTH+7)/8)*8-1:0]     s_axis_tdata,   // old_temp

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((TEMP_WIDTH+7)/8)*8-1:0]     m_axis_tdata,   // new_temp
    output logic [0:0]                          m_axis_tuser,   // row_end
    output logic                                m_axis_tlast,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hds_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [hds_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [hds_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int TW  = TEMP_WIDTH;
    localparam int TDW = ((TEMP_WIDTH + 7) / 8) * 8;
    localparam int SAW = TW + 2;
    localparam int QW  = 2 + TW + 2 * SAW;

    hds_pkg::t_cfg                  cfg;
    logic [hds_pkg::Q_LVL_W-1:0]    q_level;
    logic                           q_push;
    logic                           q_pop;
    logic                           q_valid;
    logic [QW-1:0]                  q_wdata;
    logic [QW-1:0]                  q_rdata;

    logic signed [TW-1:0]           f_centre;
    logic signed [SAW-1:0]          f_sum_a;
    logic signed [SAW-1:0]          f_sum_b;
    hds_pkg::t_flags                f_flags;

    hds_pkg::t_flags                b_flags;
    logic signed [TW-1:0]           b_centre;
    logic signed [SAW-1:0]          b_sum_a;
    logic signed [SAW-1:0]          b_sum_b;

    logic signed [TW-1:0]           out_temp;
    hds_pkg::t_flags                out_flags;

    hds_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hds_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .TEMP_WIDTH (TEMP_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (s_axis_tvalid),
        .i_temp    (s_axis_tdata[TW-1:0]),
        .o_ready   (s_axis_tready),
        .i_q_level (q_level),
        .o_push    (q_push),
        .o_centre  (f_centre),
        .o_sum_a   (f_sum_a),
        .o_sum_b   (f_sum_b),
        .o_flags   (f_flags)
    );

    assign q_wdata = {f_flags, f_centre, f_sum_a, f_sum_b};

    hds_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .o_level (q_level)
    );

    assign {b_flags, b_centre, b_sum_a, b_sum_b} = q_rdata;

    hds_back #(
        .TEMP_WIDTH (TEMP_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_k       (cfg.conduct_k),
        .i_q_valid (q_valid),
        .i_centre  (b_centre),
        .i_sum_a   (b_sum_a),
        .i_sum_b   (b_sum_b),
        .i_flags   (b_flags),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_temp    (out_temp),
        .o_flags   (out_flags)
    );

    assign m_axis_tdata    = TDW'($unsigned(out_temp));
    assign m_axis_tuser[0] = out_flags.row_end;
    assign m_axis_tlast    = out_flags.grid_end;

endmodule

// File: hw/rtl/hds_cfg.sv
module hds_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hds_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [hds_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [hds_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    output hds_pkg::t_cfg                       o_cfg
);

    hds_pkg::t_cfg     r_cfg;
    hds_pkg::t_reg_idx reg_idx;

    assign reg_idx = hds_pkg::t_reg_idx'(paddr[hds_pkg::CFG_ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.conduct_k <= hds_pkg::K_RESET;
            r_cfg.grid_cols <= hds_pkg::SIZE_RESET;
            r_cfg.grid_rows <= hds_pkg::SIZE_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                hds_pkg::REG_CONDUCT_K: r_cfg.conduct_k <= pwdata[hds_pkg::K_W-1:0];
                hds_pkg::REG_GRID_COLS: r_cfg.grid_cols <= pwdata[hds_pkg::SIZE_CFG_W-1:0];
                hds_pkg::REG_GRID_ROWS: r_cfg.grid_rows <= pwdata[hds_pkg::SIZE_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            hds_pkg::REG_CONDUCT_K:
                prdata = hds_pkg::CFG_DATA_W'(r_cfg.conduct_k);
            hds_pkg::REG_GRID_COLS:
                prdata = hds_pkg::CFG_DATA_W'(r_cfg.grid_cols);
            hds_pkg::REG_GRID_ROWS:
                prdata = hds_pkg::CFG_DATA_W'(r_cfg.grid_rows);
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/hds_front.sv
module hds_front #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int TEMP_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hds_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    input  logic [TEMP_WIDTH-1:0]               i_temp,
    output logic                                o_ready,
    input  logic [hds_pkg::Q_LVL_W-1:0]         i_q_level,
    output logic                                o_push,
    output logic signed [TEMP_WIDTH-1:0]        o_centre,
    output logic signed [TEMP_WIDTH+1:0]        o_sum_a,
    output logic signed [TEMP_WIDTH+1:0]        o_sum_b,
    output hds_pkg::t_flags                     o_flags
);

    localparam int TW   = TEMP_WIDTH;
    localparam int SAW  = TW + 2;
    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CW1  = $clog2(MAX_COLS + 1);
    localparam int RW1  = $clog2(MAX_ROWS + 1);
    localparam int SZ_A = (CW1 > RW1) ? CW1 : RW1;
    localparam int SZ_W = (SZ_A > hds_pkg::SIZE_CFG_W) ? SZ_A : hds_pkg::SIZE_CFG_W;

    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [SZ_W-1:0] cols_c;
    logic [SZ_W-1:0] rows_c;
    logic [SZ_W-1:0] cols_raw;
    logic [SZ_W-1:0] rows_raw;
    logic            last_col;
    logic            last_row;
    logic            accept;

    // line stores: upper row in the high half, middle row in the low half
    logic [2*TW-1:0] line_mem [MAX_COLS];
    logic [2*TW-1:0] r_rd;

    logic                 r_s1_valid;
    logic                 r_s1_int;
    logic [CW-1:0]        r_s1_idx;
    logic signed [TW-1:0] r_s1_bot;
    hds_pkg::t_flags      r_s1_flags;

    logic signed [TW-1:0] r_win [6];
    logic signed [TW-1:0] rd_top;
    logic signed [TW-1:0] rd_mid;

    assign cols_raw = SZ_W'(i_cfg.grid_cols);
    assign rows_raw = SZ_W'(i_cfg.grid_rows);

    always_comb begin
        if (cols_raw < SZ_W'(hds_pkg::SIZE_MIN))
            cols_c = SZ_W'(hds_pkg::SIZE_MIN);
        else if (cols_raw > SZ_W'(MAX_COLS))
            cols_c = SZ_W'(MAX_COLS);
        else
            cols_c = cols_raw;
        if (rows_raw < SZ_W'(hds_pkg::SIZE_MIN))
            rows_c = SZ_W'(hds_pkg::SIZE_MIN);
        else if (rows_raw > SZ_W'(MAX_ROWS))
            rows_c = SZ_W'(MAX_ROWS);
        else
            rows_c = rows_raw;
    end

    assign last_col = (SZ_W'(r_col) + SZ_W'(1)) >= cols_c;
    assign last_row = (SZ_W'(r_row) + SZ_W'(1)) >= rows_c;

    // credit: the queue must hold everything already on its way
    assign o_ready = (i_q_level + hds_pkg::Q_LVL_W'(r_s1_valid && r_s1_int))
                     < hds_pkg::Q_LVL_W'(hds_pkg::Q_DEPTH);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_int            <= (r_col >= CW'(2)) && (r_row >= RW'(2));
            r_s1_idx            <= r_col;
            r_s1_bot            <= i_temp;
            r_s1_flags.row_end  <= last_col;
            r_s1_flags.grid_end <= last_col && last_row;
        end
    end

    // write follows the read in the next cycle; neighbouring beats never share a column
    always_ff @(posedge i_clk) begin
        if (accept)
            r_rd <= line_mem[r_col];
        if (r_s1_valid)
            line_mem[r_s1_idx] <= {rd_mid, r_s1_bot};
    end

    assign rd_top = r_rd[2*TW-1:TW];
    assign rd_mid = r_rd[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++)
                r_win[i] <= '0;
        end else if (r_s1_valid) begin
            r_win[0] <= r_win[1];
            r_win[1] <= rd_top;
            r_win[2] <= r_win[3];
            r_win[3] <= rd_mid;
            r_win[4] <= r_win[5];
            r_win[5] <= r_s1_bot;
        end
    end

    assign o_push   = r_s1_valid && r_s1_int;
    assign o_centre = r_win[3];
    assign o_flags  = r_s1_flags;
    assign o_sum_a  = SAW'(r_win[0]) + SAW'(r_win[1]) + SAW'(rd_top) + SAW'(r_win[2]);
    assign o_sum_b  = SAW'(rd_mid) + SAW'(r_win[4]) + SAW'(r_win[5]) + SAW'(r_s1_bot);

endmodule

// File: hw/rtl/hds_fifo.sv
module hds_fifo #(
    parameter int WIDTH = 104
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic [WIDTH-1:0]                i_data,
    input  logic                            i_pop,
    output logic                            o_valid,
    output logic [WIDTH-1:0]                o_data,
    output logic [hds_pkg::Q_LVL_W-1:0]     o_level
);

    logic [WIDTH-1:0]                r_mem [hds_pkg::Q_DEPTH];
    logic [hds_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [hds_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [hds_pkg::Q_LVL_W-1:0]     r_level;
    logic                            do_pop;

    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_level;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + hds_pkg::Q_PTR_W'(1);
            if (do_pop)
                r_rd_ptr <= r_rd_ptr + hds_pkg::Q_PTR_W'(1);
            r_level <= r_level + hds_pkg::Q_LVL_W'(i_push) - hds_pkg::Q_LVL_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// File: hw/rtl/hds_back.sv
module hds_back #(
    parameter int TEMP_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [hds_pkg::K_W-1:0]             i_k,
    input  logic                                i_q_valid,
    input  logic signed [TEMP_WIDTH-1:0]        i_centre,
    input  logic signed [TEMP_WIDTH+1:0]        i_sum_a,
    input  logic signed [TEMP_WIDTH+1:0]        i_sum_b,
    input  hds_pkg::t_flags                     i_flags,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [TEMP_WIDTH-1:0]        o_temp,
    output hds_pkg::t_flags                     o_flags
);

    localparam int TW     = TEMP_WIDTH;
    localparam int SW     = TW + 3;
    localparam int PW     = SW + hds_pkg::K_W + 1;
    localparam int TERM_W = PW - hds_pkg::K_FRAC_SHIFT;
    localparam int AW     = TW + 4;

    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    logic                 rdy1;
    logic                 rdy2;
    logic                 rdy3;

    logic signed [SW-1:0] r_sum8;
    logic signed [TW-1:0] r_c1;
    hds_pkg::t_flags      r_f1;
    logic signed [PW-1:0] r_prod;
    logic signed [TW-1:0] r_c2;
    hds_pkg::t_flags      r_f2;
    logic signed [TW-1:0] r_out;
    hds_pkg::t_flags      r_f3;

    logic signed [TERM_W-1:0] term;
    logic signed [AW-1:0]     total;
    logic signed [AW-2:0]     half;
    logic signed [TW-1:0]     sat;
    logic                     fits;

    assign rdy3  = !r_v3 || i_ready;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign o_pop = i_q_valid && rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1)
                r_v1 <= i_q_valid;
            if (rdy2)
                r_v2 <= r_v1;
            if (rdy3)
                r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sum8 <= SW'(i_sum_a) + SW'(i_sum_b);
            r_c1   <= i_centre;
            r_f1   <= i_flags;
        end
        if (r_v1 && rdy2) begin
            r_prod <= PW'(r_sum8) * PW'($signed({1'b0, i_k}));
            r_c2   <= r_c1;
            r_f2   <= r_f1;
        end
        if (r_v2 && rdy3) begin
            r_out <= sat;
            r_f3  <= r_f2;
        end
    end

    // floor shifts: drop low bits of two's complement values
    assign term  = r_prod[PW-1:hds_pkg::K_FRAC_SHIFT];
    assign total = AW'(r_c2) + AW'(term);
    assign half  = total[AW-1:1];
    assign fits  = (&half[AW-2:TW-1]) || !(|half[AW-2:TW-1]);

    always_comb begin
        if (fits)
            sat = half[TW-1:0];
        else if (half[AW-2])
            sat = {1'b1, {(TW-1){1'b0}}};
        else
            sat = {1'b0, {(TW-1){1'b1}}};
    end

    assign o_valid = r_v3;
    assign o_temp  = r_out;
    assign o_flags = r_f3;

endmodule
